@@ sv/mraf_pkg.sv @@
// Package for the multichannel range averager and framer.
// Holds sizes, frame constants, the reciprocal for the window divide and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package mraf_pkg;

  // Block configuration.
  localparam int NUM_CHANNELS = 8;
  localparam int WINDOW       = 3;

  // Field widths of the stream words.
  localparam int CHAN_W = 3;
  localparam int DIST_W = 16;
  localparam int BYTE_W = 8;
  localparam int IN_TDATA_W = ((CHAN_W + DIST_W + 7) / 8) * 8;

  // Derived index widths.
  localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FRAME_LEN  = 2 + 2 * NUM_CHANNELS;
  localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

  // Sum of one ring and its divide by WINDOW through a rounded-up reciprocal.
  // With the shift set to the sum width plus ceil(log2(WINDOW)) the product
  // gives the exact floor for every sum the ring can produce.
  localparam int SUM_W   = DIST_W + $clog2(WINDOW);
  localparam int DIV_SH  = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = DIV_SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // Reading code and frame bytes.
  localparam logic [DIST_W-1:0] INVALID_READING = 16'hFFFF;
  localparam logic [BYTE_W-1:0] SYNC_FIRST      = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND     = 8'h55;

  localparam logic [BYTE_IDX_W-1:0] IDX_SYNC_FIRST  = BYTE_IDX_W'(0);
  localparam logic [BYTE_IDX_W-1:0] IDX_SYNC_SECOND = BYTE_IDX_W'(1);
  localparam logic [BYTE_IDX_W-1:0] IDX_AVG_BASE    = BYTE_IDX_W'(2);
  localparam logic [BYTE_IDX_W-1:0] IDX_LAST        = BYTE_IDX_W'(FRAME_LEN - 1);

  // One channel's ring of samples.
  typedef logic [WINDOW-1:0][DIST_W-1:0] hist_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  capture;   // take the input word into the item register
    logic                  update;    // write the ring and slot, register the ring sum
    logic                  divide;    // write the channel average
    logic                  load_out;  // load the output register with a frame byte
    logic [BYTE_IDX_W-1:0] byte_idx;  // which frame byte to load
  } mraf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;  // held channel names an existing channel
    logic is_last;   // held channel is the last channel
    logic out_free;  // output register can take a byte this cycle
  } mraf_stat_t;

endpackage

@@ sv/mraf_ctrl.sv @@
// Controller for the multichannel range averager and framer.
// Steps items through capture, ring update and divide, and after the last
// channel paces the frame into the output register. Depends on mraf_pkg.
`timescale 1ns / 1ps

module mraf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  mraf_pkg::mraf_stat_t stat,
  output mraf_pkg::mraf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FRAME
  } state_t;

  localparam logic [mraf_pkg::BYTE_IDX_W-1:0] BYTE_IDX_ONE = mraf_pkg::BYTE_IDX_W'(1);

  state_t                          state_r, state_nxt;
  logic [mraf_pkg::BYTE_IDX_W-1:0] byte_idx_r, byte_idx_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state, byte counter and commands.
  always_comb begin
    state_nxt    = state_r;
    byte_idx_nxt = byte_idx_r;
    cmd          = '0;
    cmd.byte_idx = byte_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // A channel beyond the configured count leaves no trace.
        if (stat.in_range) begin
          cmd.update = 1'b1;
          state_nxt  = ST_DIVIDE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.divide   = 1'b1;
        byte_idx_nxt = '0;
        state_nxt    = stat.is_last ? ST_FRAME : ST_IDLE;
      end
      ST_FRAME: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (byte_idx_r == mraf_pkg::IDX_LAST) begin
            byte_idx_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            byte_idx_nxt = byte_idx_r + BYTE_IDX_ONE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register and byte counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

endmodule

@@ sv/mraf_datapath.sv @@
// Datapath for the multichannel range averager and framer.
// Holds the sample rings, write slots, averages, the sum and divide stages
// and the output word register. Depends on mraf_pkg.
`timescale 1ns / 1ps

module mraf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mraf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [mraf_pkg::BYTE_W-1:0]       out_tdata,
  output logic                              out_tlast,
  input  mraf_pkg::mraf_cmd_t               cmd,
  output mraf_pkg::mraf_stat_t              stat
);

  // Held input item.
  logic [mraf_pkg::CHAN_W-1:0] chan_r;
  logic [mraf_pkg::DIST_W-1:0] dist_r;

  // Channel state.
  mraf_pkg::hist_row_t           hist_r [mraf_pkg::NUM_CHANNELS];
  logic [mraf_pkg::SLOT_W-1:0]   slot_r [mraf_pkg::NUM_CHANNELS];
  logic [mraf_pkg::DIST_W-1:0]   avg_r  [mraf_pkg::NUM_CHANNELS];

  // Sum stage and output register.
  logic [mraf_pkg::SUM_W-1:0]  sum_r;
  logic                        out_valid_r;
  logic [mraf_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_last_r;

  logic [mraf_pkg::CH_IDX_W-1:0] ch_idx;
  logic                          dist_ok;
  logic [mraf_pkg::SLOT_W-1:0]   cur_slot;
  logic [mraf_pkg::SLOT_W-1:0]   slot_nxt;
  mraf_pkg::hist_row_t           row_nxt;
  logic [mraf_pkg::SUM_W-1:0]    sum_nxt;
  logic [mraf_pkg::PROD_W-1:0]   prod;
  logic [mraf_pkg::DIST_W-1:0]   avg_nxt;
  logic [mraf_pkg::BYTE_IDX_W-1:0] avg_off;
  logic [mraf_pkg::CH_IDX_W-1:0] frm_ch;
  logic [mraf_pkg::DIST_W-1:0]   frm_avg;
  logic [mraf_pkg::BYTE_W-1:0]   byte_nxt;

  // Channel range checks on the held item.
  assign ch_idx        = mraf_pkg::CH_IDX_W'(chan_r);
  assign stat.in_range = (32'(chan_r) < 32'(mraf_pkg::NUM_CHANNELS));
  assign stat.is_last  = (32'(chan_r) == 32'(mraf_pkg::NUM_CHANNELS - 1));
  assign stat.out_free = !out_valid_r || out_tready;

  // Ring write and slot advance for the held reading.
  always_comb begin
    dist_ok  = (dist_r != mraf_pkg::INVALID_READING);
    cur_slot = slot_r[ch_idx];
    if (32'(cur_slot) >= 32'(mraf_pkg::WINDOW)) begin
      cur_slot = '0;
    end
    if (32'(cur_slot) + 1 >= 32'(mraf_pkg::WINDOW)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = cur_slot + mraf_pkg::SLOT_W'(1);
    end
    row_nxt = hist_r[ch_idx];
    if (dist_ok) begin
      row_nxt[cur_slot] = dist_r;
    end
  end

  // Sum over the updated ring.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < mraf_pkg::WINDOW; i++) begin
      sum_nxt = sum_nxt + mraf_pkg::SUM_W'(row_nxt[i]);
    end
  end

  // Divide by the window length through the reciprocal.
  assign prod    = mraf_pkg::PROD_W'(sum_r) * mraf_pkg::PROD_W'(mraf_pkg::RECIP);
  assign avg_nxt = prod[mraf_pkg::DIV_SH +: mraf_pkg::DIST_W];

  // Frame byte selection: two sync bytes, then each average high byte first.
  always_comb begin
    avg_off = cmd.byte_idx - mraf_pkg::IDX_AVG_BASE;
    frm_ch  = mraf_pkg::CH_IDX_W'(avg_off >> 1);
    frm_avg = avg_r[frm_ch];
    if (cmd.byte_idx == mraf_pkg::IDX_SYNC_FIRST) begin
      byte_nxt = mraf_pkg::SYNC_FIRST;
    end else if (cmd.byte_idx == mraf_pkg::IDX_SYNC_SECOND) begin
      byte_nxt = mraf_pkg::SYNC_SECOND;
    end else if (!avg_off[0]) begin
      byte_nxt = frm_avg[mraf_pkg::DIST_W-1 -: mraf_pkg::BYTE_W];
    end else begin
      byte_nxt = frm_avg[mraf_pkg::BYTE_W-1:0];
    end
  end

  // Item capture and sum register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chan_r <= in_tdata[mraf_pkg::CHAN_W-1:0];
      dist_r <= in_tdata[mraf_pkg::CHAN_W +: mraf_pkg::DIST_W];
    end
    if (cmd.update) begin
      sum_r <= sum_nxt;
    end
  end

  // Rings, slots and averages, all zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < mraf_pkg::NUM_CHANNELS; c++) begin
        hist_r[c] <= '0;
        slot_r[c] <= '0;
        avg_r[c]  <= '0;
      end
    end else begin
      if (cmd.update) begin
        hist_r[ch_idx] <= row_nxt;
        if (dist_ok) begin
          slot_r[ch_idx] <= slot_nxt;
        end
      end
      if (cmd.divide) begin
        avg_r[ch_idx] <= avg_nxt;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r <= byte_nxt;
      out_last_r <= (cmd.byte_idx == mraf_pkg::IDX_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

@@ sv/multichannel_range_averager_framer.sv @@
// Top level of the multichannel range averager and framer.
// Joins the controller and the datapath. Depends on mraf_pkg, mraf_ctrl
// and mraf_datapath.
//
//   Channel  Direction  Word contents (tdata from bit 0 up)          Marker
//   in_      slave      channel[2:0], distance[18:3], zero pad to 24  -
//   out_     master     out_byte[7:0]                                 tlast = frame_last
//
// Each reading passes through capture, ring update with sum, and divide.
// A reading on the last channel then streams the frame at one word a cycle
// from the output register while the output does not stall.
// Reset is synchronous and clears rings, slots, averages and control state.
// A stall on the output holds the frame; the next reading is taken while the
// final frame word still waits in the output register.
`timescale 1ns / 1ps

module multichannel_range_averager_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mraf_pkg::IN_TDATA_W-1:0] in_tdata,    // channel, distance
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mraf_pkg::BYTE_W-1:0]     out_tdata,   // out_byte
  output logic                            out_tlast
);

  mraf_pkg::mraf_cmd_t  cmd;
  mraf_pkg::mraf_stat_t stat;

  // Sequencer.
  mraf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, arithmetic and output register.
  mraf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

@@ tb/multichannel_range_averager_framer_test.sv @@
// Self-checking testbench for multichannel_range_averager_framer.
// Drives distance readings, predicts each channel's window average and the
// sync-framed byte stream, and compares every output word. Needs mraf_pkg.
`timescale 1ns / 1ps

module multichannel_range_averager_framer_test;

  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYCS = 40;

  typedef logic [mraf_pkg::CHAN_W-1:0] chan_t;
  typedef logic [mraf_pkg::DIST_W-1:0] dist_t;

  // One expected frame word.
  typedef struct packed {
    logic [mraf_pkg::BYTE_W-1:0] data;
    logic                        last;
  } frame_byte_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [mraf_pkg::IN_TDATA_W-1:0] in_tdata = '0;      // channel, distance, zero pad
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mraf_pkg::BYTE_W-1:0]     out_tdata;          // out_byte
  logic                            out_tlast;

  // Predicted block state: sample rings, write slots and averages.
  dist_t       ring_samples [mraf_pkg::NUM_CHANNELS][mraf_pkg::WINDOW] =
    '{default: '{default: '0}};
  int unsigned ring_slot    [mraf_pkg::NUM_CHANNELS] = '{default: 0};
  dist_t       chan_average [mraf_pkg::NUM_CHANNELS] = '{default: '0};

  frame_byte_t frame_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;

  always #1 clk = ~clk;

  multichannel_range_averager_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Update the predicted rings for one accepted reading and queue the frame
  // that a reading on the last channel produces.
  function automatic void predict_reading(input chan_t ch, input dist_t distance);
    int unsigned sum;
    int unsigned slot;
    int          c;
    sum = 0;
    if (int'(ch) >= mraf_pkg::NUM_CHANNELS) return;
    if (distance != mraf_pkg::INVALID_READING) begin
      slot = (ring_slot[ch] >= mraf_pkg::WINDOW) ? 0 : ring_slot[ch];
      ring_samples[ch][slot] = distance;
      ring_slot[ch] = (slot + 1 >= mraf_pkg::WINDOW) ? 0 : slot + 1;
    end
    for (int i = 0; i < mraf_pkg::WINDOW; i++) sum += ring_samples[ch][i];
    chan_average[ch] = mraf_pkg::DIST_W'(sum / mraf_pkg::WINDOW);
    if (int'(ch) != mraf_pkg::NUM_CHANNELS - 1) return;
    frame_q.push_back('{data: mraf_pkg::SYNC_FIRST, last: 1'b0});
    frame_q.push_back('{data: mraf_pkg::SYNC_SECOND, last: 1'b0});
    for (c = 0; c < mraf_pkg::NUM_CHANNELS; c++) begin
      frame_q.push_back('{data: chan_average[c][15:8], last: 1'b0});
      frame_q.push_back('{data: chan_average[c][7:0],
                          last: (c == mraf_pkg::NUM_CHANNELS - 1)});
    end
  endfunction

  // Offer one reading, with a random gap first, and wait for the handshake.
  task automatic send_reading(input chan_t ch, input dist_t distance);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= mraf_pkg::IN_TDATA_W'({distance, ch});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_reading(ch, distance);
  endtask

  // Mostly ordinary distances, with invalid codes and the ends of the range.
  function automatic dist_t pick_distance();
    case ($urandom_range(9))
      0:       return mraf_pkg::INVALID_READING;
      1:       return dist_t'(mraf_pkg::INVALID_READING - $urandom_range(3) - 1);
      2:       return dist_t'($urandom_range(15));
      default: return dist_t'($urandom_range(65535));
    endcase
  endfunction

  // Field extremes, ring wrap, invalid readings and frames on the last channel.
  task automatic test_directed_extremes();
    send_reading(3'd0, 16'd0);
    send_reading(3'd0, 16'd65534);
    send_reading(3'd0, mraf_pkg::INVALID_READING);
    send_reading(3'd0, 16'd65534);
    send_reading(3'd0, 16'd65534);
    send_reading(3'd0, 16'd65534);
    send_reading(3'd1, 16'h5555);
    send_reading(3'd2, 16'hAAAA);
    send_reading(3'd3, 16'd1);
    send_reading(3'd4, 16'h8000);
    send_reading(3'd5, 16'h7FFF);
    send_reading(3'd6, 16'h00FF);
    send_reading(3'd7, mraf_pkg::INVALID_READING);
    send_reading(3'd7, 16'hFF00);
    send_reading(3'd7, 16'd12345);
    send_reading(3'd7, 16'd65534);
    send_reading(3'd7, 16'd65534);
    send_reading(3'd3, mraf_pkg::INVALID_READING);
    send_reading(3'd6, 16'd2);
    send_reading(3'd7, 16'd0);
  endtask

  // Channel sweeps in order, each ending in a frame; a few skip a channel.
  task automatic test_frame_sweeps(input int sweeps);
    for (int s = 0; s < sweeps; s++) begin
      for (int c = 0; c < mraf_pkg::NUM_CHANNELS; c++) begin
        if (c == mraf_pkg::NUM_CHANNELS - 1 || $urandom_range(11) != 0)
          send_reading(chan_t'(c), pick_distance());
      end
    end
  endtask

  // Readings on random channels in no particular order.
  task automatic test_random_readings(input int count);
    for (int n = 0; n < count; n++)
      send_reading(chan_t'($urandom_range(mraf_pkg::NUM_CHANNELS - 1)), pick_distance());
  endtask

  // Receiver: random back-pressure and the check of each accepted word.
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output word %02h last %0b",
                                  out_tdata, out_tlast));
      end else begin
        want = frame_q.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("frame byte %02h, expected %02h", out_tdata, want.data));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", out_tlast, want.last));
      end
    end
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multichannel_range_averager_framer: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver stalls often.
    src_idle_pct  = 12;
    sink_idle_pct = 48;
    test_directed_extremes();
    test_frame_sweeps(6);

    // Sender idles often, receiver stalls lightly.
    src_idle_pct  = 48;
    sink_idle_pct = 12;
    test_frame_sweeps(5);
    test_random_readings(40);

    // Full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_frame_sweeps(5);
    test_random_readings(80);

    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);

    if (mismatch_count == 0)
      $display("multichannel_range_averager_framer: match");
    else
      $display("multichannel_range_averager_framer: mismatch");
    $finish;
  end

endmodule
